### design/spq_pkg.sv
// Shared types and default sizes for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

### design/spq_cell.sv
// One storage cell of the sorted chain: compare, hold, insert or shift.
module spq_cell #(
    parameter int ELEM_WIDTH = spq_pkg::ELEM_WIDTH,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic [PRIO_WIDTH-1:0] i_new_prio,
    input  logic [ELEM_WIDTH-1:0] i_new_elem,
    input  logic                  i_prev_keep,
    input  logic [PRIO_WIDTH-1:0] i_prev_prio,
    input  logic [ELEM_WIDTH-1:0] i_prev_elem,
    input  logic [PRIO_WIDTH-1:0] i_next_prio,
    input  logic [ELEM_WIDTH-1:0] i_next_elem,
    output logic                  o_keep,
    output logic [PRIO_WIDTH-1:0] o_prio,
    output logic [ELEM_WIDTH-1:0] o_elem
);
    import spq_pkg::*;

    logic [PRIO_WIDTH-1:0] r_prio;
    logic [PRIO_WIDTH-1:0] n_prio;
    logic [ELEM_WIDTH-1:0] r_elem;
    logic [ELEM_WIDTH-1:0] n_elem;
    logic                  keep;

    assign keep = i_occupied && (r_prio <= i_new_prio);

    always_comb begin
        n_prio = r_prio;
        n_elem = r_elem;
        if (i_ctl.deq) begin
            n_prio = i_next_prio;
            n_elem = i_next_elem;
        end else if (i_ctl.enq && !keep) begin
            if (i_prev_keep) begin
                n_prio = i_new_prio;
                n_elem = i_new_elem;
            end else begin
                n_prio = i_prev_prio;
                n_elem = i_prev_elem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_elem <= n_elem;
    end

    assign o_keep = keep;
    assign o_prio = r_prio;
    assign o_elem = r_elem;

endmodule

### design/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, occupancy and result handshake.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_operation, i_element, i_priority_req
//  result    out        o_valid / i_stall   o_head_element, o_head_priority, o_count,
//                                           o_is_empty, o_error
//
// One item per cycle while o_stall is low: every cell compares against the new
// priority and loads, holds or shifts in the same cycle.
// The result of an item shows in the cycle after it is accepted and holds while stalled;
// no new item is taken while an unread result is stalled.
// Reset (synchronous, i_rst_n low) empties the queue and drops any pending result.
module sorted_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH,
    parameter int ELEM_WIDTH = spq_pkg::ELEM_WIDTH,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [ELEM_WIDTH-1:0] i_element,
    input  logic [PRIO_WIDTH-1:0] i_priority_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ELEM_WIDTH-1:0] o_head_element,
    output logic [PRIO_WIDTH-1:0] o_head_priority,
    output logic [CNT_W-1:0]      o_count,
    output logic                  o_is_empty,
    output logic                  o_error
);
    import spq_pkg::*;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_error;
    logic                  n_error;

    logic                  accept;
    logic                  full;
    logic                  empty;
    t_op                   op;
    t_cell_ctl             ctl;

    logic [DEPTH-1:0]      occ;
    logic [DEPTH-1:0]      keep;
    logic [PRIO_WIDTH-1:0] prio [DEPTH];
    logic [ELEM_WIDTH-1:0] elem [DEPTH];

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign op      = t_op'(i_operation);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);

    always_comb begin
        ctl.enq     = accept && (op == OP_ENQ) && !full;
        ctl.deq     = accept && (op == OP_DEQ) && !empty;
        n_count     = r_count;
        n_error     = r_error;
        n_out_valid = r_out_valid && i_stall;
        if (ctl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.deq) begin
            n_count = r_count - CNT_W'(1);
        end
        if (accept) begin
            n_out_valid = 1'b1;
            n_error     = ((op == OP_ENQ) && full) || ((op == OP_DEQ) && empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_error     <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_error     <= n_error;
        end
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                  prev_keep;
        logic [PRIO_WIDTH-1:0] prev_prio;
        logic [ELEM_WIDTH-1:0] prev_elem;
        logic [PRIO_WIDTH-1:0] next_prio;
        logic [ELEM_WIDTH-1:0] next_elem;

        assign occ[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign prev_keep = 1'b1;
            assign prev_prio = i_priority_req;
            assign prev_elem = i_element;
        end else begin : g_mid
            assign prev_keep = keep[gi-1];
            assign prev_prio = prio[gi-1];
            assign prev_elem = elem[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign next_prio = prio[gi];
            assign next_elem = elem[gi];
        end else begin : g_inner
            assign next_prio = prio[gi+1];
            assign next_elem = elem[gi+1];
        end

        spq_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (occ[gi]),
            .i_new_prio  (i_priority_req),
            .i_new_elem  (i_element),
            .i_prev_keep (prev_keep),
            .i_prev_prio (prev_prio),
            .i_prev_elem (prev_elem),
            .i_next_prio (next_prio),
            .i_next_elem (next_elem),
            .o_keep      (keep[gi]),
            .o_prio      (prio[gi]),
            .o_elem      (elem[gi])
        );
    end

    assign o_valid         = r_out_valid;
    assign o_head_element  = empty ? '0 : elem[0];
    assign o_head_priority = empty ? '0 : prio[0];
    assign o_count         = r_count;
    assign o_is_empty      = empty;
    assign o_error         = r_error;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (((op == OP_ENQ) && full) || ((op == OP_DEQ) && empty)))
        |=> (r_error && $stable(r_count)))
        else $error("rejected item changed occupancy");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (prio[0] <= prio[1]))
        else $error("head entries out of order");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("occupancy changed without an item");

endmodule

### tb/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue with random handshake idling.
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int CNT_W           = $clog2(DEPTH + 1);
    localparam int PRESSURE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_ITEMS    = 960;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] head_element;
        logic [PRIO_WIDTH-1:0] head_priority;
        logic [CNT_W-1:0]      count;
        logic                  is_empty;
        logic                  error;
    } t_head_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_operation;
    logic [ELEM_WIDTH-1:0] i_element;
    logic [PRIO_WIDTH-1:0] i_priority_req;
    logic                  o_valid;
    logic                  i_stall;
    logic [ELEM_WIDTH-1:0] o_head_element;
    logic [PRIO_WIDTH-1:0] o_head_priority;
    logic [CNT_W-1:0]      o_count;
    logic                  o_is_empty;
    logic                  o_error;

    sorted_priority_queue dut (.*);

    logic [PRIO_WIDTH-1:0] shadow_prio [DEPTH];
    logic [ELEM_WIDTH-1:0] shadow_elem [DEPTH];
    int                    shadow_len;
    t_head_report          expected_heads [$];

    int  mismatches;
    int  results_checked;
    int  enq_sent;
    int  deq_sent;
    int  full_rejects;
    int  empty_rejects;
    int  burst_left;
    int  idle_cycles;
    bit  pressure_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_head_report apply_queue_op(input t_op op,
                                                    input logic [ELEM_WIDTH-1:0] elem,
                                                    input logic [PRIO_WIDTH-1:0] prio);
        t_head_report rpt;
        int           slot;
        int           k;
        rpt.error = 1'b0;
        if (op == OP_DEQ) begin
            if (shadow_len == 0) begin
                rpt.error = 1'b1;
            end else begin
                for (k = 1; k < shadow_len; k++) begin
                    shadow_prio[k-1] = shadow_prio[k];
                    shadow_elem[k-1] = shadow_elem[k];
                end
                shadow_len--;
            end
        end else begin
            if (shadow_len >= DEPTH) begin
                rpt.error = 1'b1;
            end else begin
                slot = 0;
                while (slot < shadow_len && shadow_prio[slot] <= prio)
                    slot++;
                for (k = shadow_len; k > slot; k--) begin
                    shadow_prio[k] = shadow_prio[k-1];
                    shadow_elem[k] = shadow_elem[k-1];
                end
                shadow_prio[slot] = prio;
                shadow_elem[slot] = elem;
                shadow_len++;
            end
        end
        rpt.head_element  = (shadow_len > 0) ? shadow_elem[0] : '0;
        rpt.head_priority = (shadow_len > 0) ? shadow_prio[0] : '0;
        rpt.count         = CNT_W'(shadow_len);
        rpt.is_empty      = (shadow_len == 0);
        return rpt;
    endfunction

    task automatic send_item(input t_op op, input logic [ELEM_WIDTH-1:0] elem,
                             input logic [PRIO_WIDTH-1:0] prio);
        t_head_report rpt;
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_element      <= elem;
        i_priority_req <= prio;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        rpt = apply_queue_op(op, elem, prio);
        expected_heads.push_back(rpt);
        if (op == OP_ENQ) begin
            enq_sent++;
            if (rpt.error) full_rejects++;
        end else begin
            deq_sent++;
            if (rpt.error) empty_rejects++;
        end
    endtask

    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 7);
        i_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_head_report want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_heads.size() == 0) begin
                $display("%0t: result with nothing expected, actual head %0h prio %0h count %0d",
                         $time, o_head_element, o_head_priority, o_count);
                mismatches++;
            end else begin
                want = expected_heads.pop_front();
                results_checked++;
                check_field("head_element", 64'(want.head_element), 64'(o_head_element));
                check_field("head_priority", 64'(want.head_priority), 64'(o_head_priority));
                check_field("count", 64'(want.count), 64'(o_count));
                check_field("is_empty", 64'(want.is_empty), 64'(o_is_empty));
                check_field("error", 64'(want.error), 64'(o_error));
            end
        end
    end

    // stall results on a pattern of random phases; hold off long on request
    initial begin
        int hold_cnt;
        int phase_left;
        int stall_pct;
        hold_cnt   = 0;
        phase_left = 0;
        stall_pct  = 0;
        i_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                hold_cnt     = PRESSURE_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(10, 60);
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_heads.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_empty_dequeue();
        send_item(OP_DEQ, '1, '1);
        send_item(OP_DEQ, '0, '0);
    endtask

    task automatic test_priority_extremes();
        send_item(OP_ENQ, '1, '1);
        send_item(OP_ENQ, '0, '0);
        send_item(OP_ENQ, 32'h0000_0001, '1);
        send_item(OP_DEQ, 32'h5555_5555, 16'haaaa);
        send_item(OP_DEQ, 32'haaaa_aaaa, 16'h5555);
    endtask

    task automatic test_fifo_ties();
        send_item(OP_ENQ, 32'h0000_00a1, 16'h0800);
        send_item(OP_ENQ, 32'h0000_00a2, 16'h0800);
        send_item(OP_ENQ, 32'h0000_00a3, 16'h0800);
        send_item(OP_DEQ, '0, '0);
    endtask

    task automatic test_full_queue();
        while (shadow_len < DEPTH)
            send_item(OP_ENQ, $urandom, PRIO_WIDTH'($urandom));
        send_item(OP_ENQ, 32'hdead_beef, '0);
        send_item(OP_ENQ, 32'hbeef_dead, '1);
        send_item(OP_DEQ, '1, '1);
        send_item(OP_ENQ, 32'hc0de_0001, 16'h0001);
    endtask

    task automatic test_backpressure();
        int i;
        pressure_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_item($urandom_range(1) ? OP_ENQ : OP_DEQ, $urandom,
                      PRIO_WIDTH'($urandom_range(15)));
    endtask

    task automatic test_random_traffic(input int n_items);
        int                    i;
        int                    phase_left;
        int                    enq_pct;
        int                    prio_mode;
        t_op                   op;
        logic [PRIO_WIDTH-1:0] prio;
        phase_left = 0;
        enq_pct    = 50;
        prio_mode  = 0;
        for (i = 0; i < n_items; i++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(8, 48);
                case ($urandom_range(2))
                    0: enq_pct = 85;
                    1: enq_pct = 20;
                    default: enq_pct = 55;
                endcase
                prio_mode = $urandom_range(3);
            end
            phase_left--;
            op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            case (prio_mode)
                0: prio = PRIO_WIDTH'($urandom);
                1: prio = PRIO_WIDTH'($urandom_range(3));
                2: prio = $urandom_range(1) ? PRIO_WIDTH'(16'hffff - $urandom_range(2))
                                            : PRIO_WIDTH'($urandom_range(2));
                default: prio = PRIO_WIDTH'($urandom_range(40, 48));
            endcase
            send_item(op, $urandom, prio);
            sender_pause();
        end
    endtask

    task automatic test_drain();
        while (shadow_len > 0)
            send_item(OP_DEQ, $urandom, PRIO_WIDTH'($urandom));
        send_item(OP_DEQ, $urandom, PRIO_WIDTH'($urandom));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_ENQ;
        i_element       = '0;
        i_priority_req  = '0;
        shadow_len      = 0;
        mismatches      = 0;
        results_checked = 0;
        enq_sent        = 0;
        deq_sent        = 0;
        full_rejects    = 0;
        empty_rejects   = 0;
        burst_left      = 0;
        idle_cycles     = 0;
        pressure_req    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_dequeue();
        test_priority_extremes();
        test_fifo_ties();
        test_full_queue();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        test_drain();
        i_valid <= 1'b0;

        while (expected_heads.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("summary: %0d items (%0d enqueue, %0d dequeue), %0d full and %0d empty rejects",
                 enq_sent + deq_sent, enq_sent, deq_sent, full_rejects, empty_rejects);
        $display("summary: %0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sorted_priority_queue.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
